### rtl/hva_pkg.sv
// hva_pkg: shared types, opcodes, error codes and defaults for the
// homogeneous vector ALU. No dependencies.
`default_nettype none
package hva_pkg;
  localparam int FracBitsDefault = 16;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_DOT = 3'd2, OP_CROSS = 3'd3,
    OP_MAG = 3'd4, OP_NORM = 3'd5, OP_EQ = 3'd6, OP_TOVEC = 3'd7
  } op_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_KIND = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_x, a_y, a_z, a_w;
    logic signed [31:0] b_x, b_y, b_z, b_w;
  } req_t;

  typedef struct packed {
    logic signed [31:0] r_x, r_y, r_z, r_w;
    logic signed [31:0] scalar_out;
    logic               is_equal;
    logic [1:0]         error_code;
  } rsp_t;
endpackage
`default_nettype wire

### rtl/homogeneous_vector_alu.sv
// homogeneous_vector_alu: pipelined Q-format ALU on homogeneous 3D operands.
// Depends on hva_pkg.
`default_nettype none
// A beat is taken when start is high and busy is low. Busy is tied low, so
// one beat can enter every cycle. Its result appears on res with done high
// for one cycle, and every opcode passes through the same stages. The
// path is 2 product/scale stages, 32 square-root stages (one root bit each),
// one divide setup stage, 64 restoring divide stages (one quotient bit each,
// used by point difference and normalize), then one output register that
// saturates and zeroes the fields on error. The receiver cannot stall, and
// beats are never dropped.
module homogeneous_vector_alu import hva_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t res
);
  localparam int SqS = 32;           // sqrt result bits (64-bit radicand)
  localparam int DvS = 64;           // quotient bits (64-bit dividend)

  // ---------- stage 1: products (each <=32x32) ----------
  typedef struct packed {
    logic [2:0] op;
    logic av, bv;
    logic signed [63:0] ax, ay, az, aw, bx, by, bz, bw;
    logic signed [63:0] m0, m1, m2, m3, m4, m5;   // per-op products
    logic signed [63:0] q0, q1, q2;                // squares / eq products
    logic signed [63:0] e0, e1, e2;
    logic signed [63:0] ww;
  } s1_t;
  s1_t s1;
  logic v1;

  function automatic logic signed [63:0] fm(input logic signed [63:0] p);
    logic signed [63:0] t;
    begin
      t = p >>> FRAC_BITS;
      if (p < 0 && (p & ((64'sd1 <<< FRAC_BITS) - 1)) != 0) t = t + 1;
      return t;
    end
  endfunction

  always_ff @(posedge clk) begin
    logic signed [63:0] ax, ay, az, aw, bx, by, bz, bw;
    ax = 64'(req.a_x); ay = 64'(req.a_y); az = 64'(req.a_z); aw = 64'(req.a_w);
    bx = 64'(req.b_x); by = 64'(req.b_y); bz = 64'(req.b_z); bw = 64'(req.b_w);
    if (rst) v1 <= 1'b0; else v1 <= start;
    s1.op <= req.req_type;
    s1.av <= (aw == 0); s1.bv <= (bw == 0);
    s1.ax <= ax; s1.ay <= ay; s1.az <= az; s1.aw <= aw;
    s1.bx <= bx; s1.by <= by; s1.bz <= bz; s1.bw <= bw;
    s1.ww <= aw * bw;
    s1.q0 <= ax * ax; s1.q1 <= ay * ay; s1.q2 <= az * az;
    s1.e0 <= bx * aw; s1.e1 <= by * aw; s1.e2 <= bz * aw;
    unique case (op_t'(req.req_type))
      OP_CROSS: begin
        s1.m0 <= ay * bz; s1.m1 <= az * by; s1.m2 <= az * bx;
        s1.m3 <= ax * bz; s1.m4 <= ax * by; s1.m5 <= ay * bx;
      end
      OP_DOT: begin
        s1.m0 <= ax * bx; s1.m1 <= ay * by; s1.m2 <= az * bz;
        s1.m3 <= '0; s1.m4 <= '0; s1.m5 <= '0;
      end
      default: begin // add/sub/eq: a*bw
        s1.m0 <= ax * bw; s1.m1 <= ay * bw; s1.m2 <= az * bw;
        s1.m3 <= '0; s1.m4 <= '0; s1.m5 <= '0;
      end
    endcase
  end

  // ---------- stage 2: scale, sum, classify ----------
  typedef struct packed {
    logic signed [63:0] r0, r1, r2, r3, sc;
    logic eq;
    logic [1:0] err;
    logic need_div, need_sq, is_norm;
    logic signed [63:0] n0, n1, n2, dv;   // numerators and divisor (pp)
    logic [63:0] sq;                      // radicand
  } s2_t;
  s2_t s2;
  logic v2;

  always_ff @(posedge clk) begin
    s2_t t;
    t = '0;
    unique case (op_t'(s1.op))
      OP_ADD: begin
        if (s1.av && s1.bv) begin
          t.r0 = s1.ax + s1.bx; t.r1 = s1.ay + s1.by; t.r2 = s1.az + s1.bz;
        end else if (s1.av) begin
          t.r0 = fm(s1.m0) + s1.bx; t.r1 = fm(s1.m1) + s1.by;
          t.r2 = fm(s1.m2) + s1.bz; t.r3 = s1.bw;
        end else if (s1.bv) begin
          t.r0 = s1.ax + fm(s1.e0); t.r1 = s1.ay + fm(s1.e1);
          t.r2 = s1.az + fm(s1.e2); t.r3 = s1.aw;
        end else t.err = ERR_KIND;
      end
      OP_SUB: begin
        if (s1.av && s1.bv) begin
          t.r0 = s1.ax - s1.bx; t.r1 = s1.ay - s1.by; t.r2 = s1.az - s1.bz;
        end else if (s1.av) t.err = ERR_KIND;
        else if (s1.bv) begin
          t.r0 = s1.ax - fm(s1.e0); t.r1 = s1.ay - fm(s1.e1);
          t.r2 = s1.az - fm(s1.e2); t.r3 = s1.aw;
        end else if (fm(s1.ww) == 0) t.err = ERR_DIV0;
        else begin
          t.need_div = 1'b1;
          t.n0 = fm(s1.m0) - fm(s1.e0); t.n1 = fm(s1.m1) - fm(s1.e1);
          t.n2 = fm(s1.m2) - fm(s1.e2); t.dv = fm(s1.ww);
        end
      end
      OP_DOT: begin
        if (s1.av && s1.bv) t.sc = fm(s1.m0) + fm(s1.m1) + fm(s1.m2);
        else t.err = ERR_KIND;
      end
      OP_CROSS: begin
        if (s1.av && s1.bv) begin
          t.r0 = fm(s1.m0) - fm(s1.m1); t.r1 = fm(s1.m2) - fm(s1.m3);
          t.r2 = fm(s1.m4) - fm(s1.m5);
        end else t.err = ERR_KIND;
      end
      OP_MAG, OP_NORM: begin
        if (!s1.av) t.err = ERR_KIND;
        else begin
          t.need_sq = 1'b1; t.is_norm = (s1.op == OP_NORM);
          t.sq = 64'(s1.q0) + 64'(s1.q1) + 64'(s1.q2);
          t.n0 = s1.ax; t.n1 = s1.ay; t.n2 = s1.az;
        end
      end
      OP_EQ: begin
        if (s1.av && s1.bv)
          t.eq = (s1.ax == s1.bx) && (s1.ay == s1.by) && (s1.az == s1.bz);
        else if (!s1.av && !s1.bv)
          t.eq = (s1.m0 == s1.e0) && (s1.m1 == s1.e1) && (s1.m2 == s1.e2);
      end
      OP_TOVEC: begin
        if (s1.av) t.err = ERR_KIND;
        else begin t.r0 = s1.ax; t.r1 = s1.ay; t.r2 = s1.az; end
      end
      default: ;
    endcase
    s2 <= t;
    if (rst) v2 <= 1'b0; else v2 <= v1;
  end

  // ---------- square-root pipeline: one result bit per stage ----------
  typedef struct packed {
    s2_t b;
    logic [63:0] rem;
    logic [SqS-1:0] root;
  } sq_t;
  sq_t sqp [0:SqS];
  logic sqv [0:SqS];
  always_comb begin
    sqp[0].b = s2; sqp[0].rem = '0; sqp[0].root = '0; sqv[0] = v2;
  end
  for (genvar k = 0; k < SqS; k++) begin : g_sq
    always_ff @(posedge clk) begin
      logic [65:0] r2, tr;
      r2 = {sqp[k].rem, sqp[k].b.sq[63-2*k -: 2]};
      tr = 66'({sqp[k].root, 2'b01});
      sqp[k+1].b <= sqp[k].b;
      if (r2 >= tr) begin
        sqp[k+1].rem  <= 64'(r2 - tr);
        sqp[k+1].root <= {sqp[k].root[SqS-2:0], 1'b1};
      end else begin
        sqp[k+1].rem  <= r2[63:0];
        sqp[k+1].root <= {sqp[k].root[SqS-2:0], 1'b0};
      end
      if (rst) sqv[k+1] <= 1'b0; else sqv[k+1] <= sqv[k];
    end
  end

  // ---------- divide setup ----------
  typedef struct packed {
    s2_t b;
    logic [2:0] sg;
    logic [63:0] d;
    logic [63:0] u0, u1, u2;
  } dset_t;
  dset_t ds;
  logic dsv;
  function automatic logic [63:0] ab(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction
  always_ff @(posedge clk) begin
    dset_t t;
    t.b = sqp[SqS].b;
    if (t.b.need_sq) begin
      t.d = 64'(sqp[SqS].root);
      t.sg = {t.b.n2 < 0, t.b.n1 < 0, t.b.n0 < 0};
      if (t.b.is_norm && sqp[SqS].root == 0) t.b.err = ERR_DIV0;
      if (!t.b.is_norm) t.b.sc = 64'(sqp[SqS].root);
    end else begin
      t.d = ab(t.b.dv);
      t.sg = {(t.b.n2 < 0) != (t.b.dv < 0), (t.b.n1 < 0) != (t.b.dv < 0),
              (t.b.n0 < 0) != (t.b.dv < 0)};
    end
    t.u0 = ab(t.b.n0) << FRAC_BITS; t.u1 = ab(t.b.n1) << FRAC_BITS;
    t.u2 = ab(t.b.n2) << FRAC_BITS;
    ds <= t;
    if (rst) dsv <= 1'b0; else dsv <= sqv[SqS];
  end

  // ---------- restoring divider pipeline: 3 lanes, one bit per stage ----------
  typedef struct packed {
    dset_t c;
    logic [63:0] p0, p1, p2;
    logic [63:0] q0, q1, q2;
  } dv_t;
  dv_t dp [0:DvS];
  logic dvv [0:DvS];
  always_comb begin
    dp[0].c = ds; dp[0].p0 = '0; dp[0].p1 = '0; dp[0].p2 = '0;
    dp[0].q0 = ds.u0; dp[0].q1 = ds.u1; dp[0].q2 = ds.u2; dvv[0] = dsv;
  end
  function automatic logic [127:0] dstep(input logic [63:0] p, q, d);
    logic [64:0] pr;
    begin
      pr = {p, q[63]};
      if (pr >= {1'b0, d}) return {64'(pr - {1'b0, d}), q[62:0], 1'b1};
      return {pr[63:0], q[62:0], 1'b0};
    end
  endfunction
  for (genvar k = 0; k < DvS; k++) begin : g_dv
    always_ff @(posedge clk) begin
      dp[k+1].c <= dp[k].c;
      {dp[k+1].p0, dp[k+1].q0} <= dstep(dp[k].p0, dp[k].q0, dp[k].c.d);
      {dp[k+1].p1, dp[k+1].q1} <= dstep(dp[k].p1, dp[k].q1, dp[k].c.d);
      {dp[k+1].p2, dp[k+1].q2} <= dstep(dp[k].p2, dp[k].q2, dp[k].c.d);
      if (rst) dvv[k+1] <= 1'b0; else dvv[k+1] <= dvv[k];
    end
  end

  // ---------- output: saturate and zero on error ----------
  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
  function automatic logic signed [31:0] ssat(input logic [63:0] m, input logic n);
    if (n) return (m > 64'd2147483648) ? 32'sh80000000 : 32'(-m);
    return (m > 64'd2147483647) ? 32'sh7fffffff : m[31:0];
  endfunction

  always_ff @(posedge clk) begin
    dset_t c;
    rsp_t o;
    c = dp[DvS].c;
    o = '0;
    o.error_code = c.b.err;
    if (c.b.err == ERR_NONE) begin
      o.r_w = sat(c.b.r3);
      o.scalar_out = sat(c.b.sc);
      o.is_equal = c.b.eq;
      if (c.b.need_div || (c.b.need_sq && c.b.is_norm)) begin
        o.r_x = ssat(dp[DvS].q0, c.sg[0]);
        o.r_y = ssat(dp[DvS].q1, c.sg[1]);
        o.r_z = ssat(dp[DvS].q2, c.sg[2]);
      end else begin
        o.r_x = sat(c.b.r0); o.r_y = sat(c.b.r1); o.r_z = sat(c.b.r2);
      end
    end
    res <= o;
    if (rst) done <= 1'b0; else done <= dvv[DvS];
  end

  assign busy = 1'b0;
endmodule
`default_nettype wire

### tb/tb.sv
// tb: self-checking bench for homogeneous_vector_alu. Predicts each result from
// the request, with its own fixed-point math, and compares every field.
// Depends on hva_pkg and the homogeneous_vector_alu RTL.
`default_nettype none
module tb;
  import hva_pkg::*;

  localparam int FB = FracBitsDefault;
  localparam int N_RANDOM = 2000;
  localparam int STALL_LIMIT = 5000;  // cycles with no beat in either direction
  localparam int DRAIN_CYCLES = 200;  // longer than the whole pipeline

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  req_t req = '0;
  rsp_t res;

  req_t pending[$];       // requests not yet offered
  rsp_t expected_rsp[$];  // predicted results, oldest first
  int n_sent = 0;
  int n_total = 0;
  int n_fail = 0;
  int quiet_cycles = 0;
  int idle_pct;

  homogeneous_vector_alu uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .res(res)
  );

  always #5 clk = ~clk;

  // ---------------- fixed-point helpers ----------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Saturating sign application to an unsigned magnitude
  function automatic longint sign_clamp(longint unsigned m, bit neg);
    if (neg) return (m > 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
    return (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
  endfunction

  // Q product, truncated toward zero
  function automatic longint qmul(longint x, longint y);
    return (x * y) / (64'sd1 <<< FB);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    longint unsigned q;
    q = (mag64(n) << FB) / mag64(d);
    return sign_clamp(q, (n < 0) != (d < 0));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // ---------------- result predictor ----------------
  function automatic rsp_t predict_result(req_t q);
    longint a[4], b[4], r[4], w, scal;
    longint unsigned ss, m;
    bit a_vec, b_vec, eq;
    logic [1:0] err;
    rsp_t p;
    a = '{longint'(q.a_x), longint'(q.a_y), longint'(q.a_z), longint'(q.a_w)};
    b = '{longint'(q.b_x), longint'(q.b_y), longint'(q.b_z), longint'(q.b_w)};
    r = '{0, 0, 0, 0};
    scal = 0;
    eq = 1'b0;
    err = ERR_NONE;
    a_vec = (a[3] == 0);
    b_vec = (b[3] == 0);
    case (op_t'(q.req_type))
      OP_ADD: begin
        if (a_vec && b_vec) begin
          for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
        end else if (a_vec) begin
          for (int i = 0; i < 3; i++) r[i] = qmul(a[i], b[3]) + b[i];
          r[3] = b[3];
        end else if (b_vec) begin
          for (int i = 0; i < 3; i++) r[i] = a[i] + qmul(b[i], a[3]);
          r[3] = a[3];
        end else begin
          err = ERR_KIND;
        end
      end
      OP_SUB: begin
        if (a_vec && b_vec) begin
          for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
        end else if (a_vec) begin
          err = ERR_KIND;
        end else if (b_vec) begin
          for (int i = 0; i < 3; i++) r[i] = a[i] - qmul(b[i], a[3]);
          r[3] = a[3];
        end else begin
          // point minus point: scale both to a common w, then divide it out
          w = qmul(a[3], b[3]);
          if (w == 0) err = ERR_DIV0;
          else for (int i = 0; i < 3; i++)
            r[i] = qdiv(qmul(a[i], b[3]) - qmul(b[i], a[3]), w);
        end
      end
      OP_DOT: begin
        if (a_vec && b_vec) scal = qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]);
        else err = ERR_KIND;
      end
      OP_CROSS: begin
        if (a_vec && b_vec) begin
          r[0] = qmul(a[1], b[2]) - qmul(a[2], b[1]);
          r[1] = qmul(a[2], b[0]) - qmul(a[0], b[2]);
          r[2] = qmul(a[0], b[1]) - qmul(a[1], b[0]);
        end else begin
          err = ERR_KIND;
        end
      end
      OP_MAG, OP_NORM: begin
        if (!a_vec) begin
          err = ERR_KIND;
        end else begin
          // raw sum of squares, no fixed-point rescale
          ss = 0;
          for (int i = 0; i < 3; i++) ss += mag64(a[i]) * mag64(a[i]);
          m = int_sqrt(ss);
          if (op_t'(q.req_type) == OP_MAG) scal = longint'(m);
          else if (m == 0) err = ERR_DIV0;
          else for (int i = 0; i < 3; i++)
            r[i] = sign_clamp((mag64(a[i]) << FB) / m, a[i] < 0);
        end
      end
      OP_EQ: begin
        if (a_vec && b_vec) begin
          eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
        end else if (!a_vec && !b_vec) begin
          eq = 1'b1;
          for (int i = 0; i < 3; i++) if (a[i] * b[3] != b[i] * a[3]) eq = 1'b0;
        end
      end
      default: begin  // OP_TOVEC
        if (a_vec) err = ERR_KIND;
        else for (int i = 0; i < 3; i++) r[i] = a[i];
      end
    endcase
    if (err != ERR_NONE) begin
      r = '{0, 0, 0, 0};
      scal = 0;
      eq = 1'b0;
    end
    p.r_x = 32'(clamp32(r[0]));
    p.r_y = 32'(clamp32(r[1]));
    p.r_z = 32'(clamp32(r[2]));
    p.r_w = 32'(clamp32(r[3]));
    p.scalar_out = 32'(clamp32(scal));
    p.is_equal = eq;
    p.error_code = err;
    return p;
  endfunction

  // ---------------- stimulus ----------------
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 32'h0004_0000);
      1: v = $urandom();
      2: case ($urandom_range(0, 5))
           0: v = 32'h8000_0000;
           1: v = 32'h7FFF_FFFF;
           2: v = 32'h0;
           3: v = 32'hFFFF_FFFF;
           4: v = 32'h1;
           default: v = 32'h0001_0000;
         endcase
      default: v = $urandom_range(0, 32'h00FF_FFFF);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // w: about 40% vectors, the rest points, often with unit-ish scale
  function automatic logic [31:0] rand_w();
    if ($urandom_range(0, 9) < 4) return 32'h0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 32'h0004_0000);
    return rand_coord();
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.req_type = op_t'($urandom_range(0, 7));
    q.a_x = rand_coord(); q.a_y = rand_coord(); q.a_z = rand_coord(); q.a_w = rand_w();
    q.b_x = rand_coord(); q.b_y = rand_coord(); q.b_z = rand_coord(); q.b_w = rand_w();
    // equality needs matching operands to find anything equal
    if (q.req_type == OP_EQ && $urandom_range(0, 1)) begin
      if (q.a_w != 0 && $urandom_range(0, 1)) begin
        // same point at doubled w
        q.a_x = $signed(q.a_x) >>> 2; q.a_y = $signed(q.a_y) >>> 2;
        q.a_z = $signed(q.a_z) >>> 2; q.a_w = $signed(q.a_w) >>> 2;
        if (q.a_w == 0) q.a_w = 32'h1;
        q.b_x = q.a_x * 2; q.b_y = q.a_y * 2; q.b_z = q.a_z * 2; q.b_w = q.a_w * 2;
      end else begin
        q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z; q.b_w = q.a_w;
      end
    end
    return q;
  endfunction

  function automatic req_t mk(op_t op, logic [31:0] ax, ay, az, aw, bx, by, bz, bw);
    req_t q;
    q.req_type = op;
    q.a_x = ax; q.a_y = ay; q.a_z = az; q.a_w = aw;
    q.b_x = bx; q.b_y = by; q.b_z = bz; q.b_w = bw;
    return q;
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;

  initial begin
    // directed: every op, each operand-kind combination of add and sub, edges
    pending.push_back(mk(OP_ADD, ONE, 2*ONE, -ONE, 0, ONE, ONE, ONE, 0));
    pending.push_back(mk(OP_ADD, MAXV, MINV, MAXV, 0, MAXV, MINV, 1, 0));      // saturate
    pending.push_back(mk(OP_ADD, ONE, ONE, ONE, 0, 5, 6, 7, 2*ONE));           // v+p
    pending.push_back(mk(OP_ADD, 5, 6, 7, 3*ONE, ONE, -ONE, ONE, 0));          // p+v
    pending.push_back(mk(OP_ADD, 1, 2, 3, ONE, 4, 5, 6, ONE));                 // p+p bad
    pending.push_back(mk(OP_SUB, MINV, MAXV, 0, 0, MAXV, MINV, 0, 0));         // v-v sat
    pending.push_back(mk(OP_SUB, 1, 2, 3, 0, 4, 5, 6, ONE));                   // v-p bad
    pending.push_back(mk(OP_SUB, 9*ONE, 1, 2, ONE, ONE, 2, 3, 0));             // p-v
    pending.push_back(mk(OP_SUB, 4*ONE, 2*ONE, 0, 2*ONE, ONE, ONE, ONE, ONE)); // p-p
    pending.push_back(mk(OP_SUB, 4*ONE, 2*ONE, 7, 1, ONE, ONE, ONE, 1));       // w product -> 0
    pending.push_back(mk(OP_SUB, MAXV, MINV, MAXV, 2, MINV, MAXV, 1, MAXV));   // quotient sat
    pending.push_back(mk(OP_DOT, MAXV, MAXV, MAXV, 0, MAXV, MAXV, MAXV, 0));
    pending.push_back(mk(OP_DOT, 1, 2, 3, ONE, 1, 2, 3, 0));                   // dot w/ point
    pending.push_back(mk(OP_CROSS, ONE, 0, 0, 0, 0, ONE, 0, 0));
    pending.push_back(mk(OP_CROSS, 1, 2, 3, 0, 1, 2, 3, MINV));                // cross w/ point
    pending.push_back(mk(OP_MAG, MINV, MINV, MINV, 0, 0, 0, 0, 0));            // largest sum
    pending.push_back(mk(OP_MAG, 1, 1, 1, ONE, 0, 0, 0, 0));                   // point bad
    pending.push_back(mk(OP_NORM, 3*ONE, -4*ONE, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(OP_NORM, 0, 0, 0, 0, 1, 1, 1, 1));                    // zero length
    pending.push_back(mk(OP_NORM, MINV, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(OP_EQ, 5, 6, 7, 0, 5, 6, 7, 0));
    pending.push_back(mk(OP_EQ, 5, 6, 7, ONE, 10, 12, 14, 2*ONE));             // scaled points
    pending.push_back(mk(OP_EQ, 5, 6, 7, 0, 5, 6, 7, ONE));                    // mixed kinds
    pending.push_back(mk(OP_TOVEC, MINV, MAXV, 1, -1, 0, 0, 0, 0));
    pending.push_back(mk(OP_TOVEC, 1, 2, 3, 0, 0, 0, 0, 0));                   // vector bad
    repeat (N_RANDOM) pending.push_back(rand_req());
    n_total = pending.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending.size() != 0 || start || expected_rsp.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && expected_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Sender idles 20% first third, 72% second third, never in the last
  always_comb begin
    if (n_sent < n_total / 3) idle_pct = 20;
    else if (n_sent < 2 * n_total / 3) idle_pct = 72;
    else idle_pct = 0;
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rsp.push_back(predict_result(req));
        n_sent++;
      end
      // hold the beat while busy; otherwise offer the next one or idle
      if (!start || !busy) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          req <= pending.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // ---------------- monitor and watchdog ----------------
  always @(posedge clk) begin
    rsp_t e;
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_rsp.size() == 0) begin
          $error("result beat with nothing outstanding");
          n_fail++;
        end else begin
          e = expected_rsp.pop_front();
          cmp_field("r_x", e.r_x, res.r_x);
          cmp_field("r_y", e.r_y, res.r_y);
          cmp_field("r_z", e.r_z, res.r_z);
          cmp_field("r_w", e.r_w, res.r_w);
          cmp_field("scalar_out", e.scalar_out, res.scalar_out);
          cmp_field("is_equal", 32'(e.is_equal), 32'(res.is_equal));
          cmp_field("error_code", 32'(e.error_code), 32'(res.error_code));
        end
      end
      if (done === 1'b1 || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
